FILE: rtl/byte_range_tag_queue_macros.svh
// Assertion macros used by the byte range tag queue checker.
// Depends on nothing; included by bare file name.
`ifndef BYTE_RANGE_TAG_QUEUE_MACROS_SVH
`define BYTE_RANGE_TAG_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define BRTQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BRTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/brtq_pkg.sv
// Shared constants, types and helpers of the byte range tag queue.
// No dependencies; used by scoped names from brtq_ctrl, the top level and the checker.
`default_nettype none

package brtq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int ECNT_W      = 5;
  localparam int ERR_W       = 2;

  localparam logic CMD_PUSH    = 1'b0;
  localparam logic CMD_CONSUME = 1'b1;

  localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL      = 2'd1;
  localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd2;
  localparam logic [ERR_W-1:0] ERR_RESERVED  = 2'd3;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    logic  rd_en;
    idx_t  rd_addr;
    logic  len_we;
    logic  tag_we;
    idx_t  wr_addr;
    word_t len_wdata;
    word_t tag_wdata;
  } ram_req_t;

  typedef struct packed {
    logic [ERR_W-1:0]  error_code;
    logic [ECNT_W-1:0] entry_count;
    logic              head_valid;
    word_t             head_tag;
  } result_t;

  function automatic idx_t ring_next(input idx_t idx);
    return (idx == idx_t'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [ECNT_W-1:0] to_entry_count(input cnt_t c);
    logic [CNT_W+ECNT_W-1:0] wide;
    wide = (CNT_W + ECNT_W)'(c);
    return wide[ECNT_W-1:0];
  endfunction

  function automatic result_t make_result(input cnt_t fill, input word_t tag,
                                          input logic [ERR_W-1:0] err);
    result_t r;
    r.head_valid  = (fill != '0);
    r.head_tag    = (fill != '0) ? tag : '0;
    r.entry_count = to_entry_count(fill);
    r.error_code  = err;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/brtq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module brtq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: rtl/brtq_ctrl.sv
// Request sequencer of the byte range tag queue: ring pointers, fill count,
// cached head tag and the read-modify-write walk over the length memory.
// Depends on brtq_pkg.
`default_nettype none

module brtq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_cmd,
  input  wire brtq_pkg::word_t   in_bytes,
  input  wire brtq_pkg::word_t   in_tag,
  input  wire logic              out_free,
  input  wire brtq_pkg::word_t   len_rdata,
  input  wire brtq_pkg::word_t   tag_rdata,
  output brtq_pkg::ram_req_t     ram_req,
  output logic                   res_load,
  output brtq_pkg::result_t      res
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_LEN_RD   = 3'd1;
  localparam logic [2:0] ST_LEN_EVAL = 3'd2;
  localparam logic [2:0] ST_TAG_RD   = 3'd3;
  localparam logic [2:0] ST_TAG_CAP  = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;

  logic [2:0]                  state_r, state_nxt;
  brtq_pkg::idx_t              head_r, head_nxt;
  brtq_pkg::idx_t              tail_r, tail_nxt;
  brtq_pkg::cnt_t              fill_r, fill_nxt;
  brtq_pkg::word_t             head_tag_r, head_tag_nxt;
  brtq_pkg::word_t             rem_r, rem_nxt;
  logic [brtq_pkg::ERR_W-1:0]  err_r, err_nxt;

  logic            accept;
  logic            full;
  brtq_pkg::word_t rem_left;
  brtq_pkg::cnt_t  fill_dec;

  assign in_ready = rst_n && (state_r == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign full     = (fill_r == brtq_pkg::cnt_t'(brtq_pkg::QUEUE_DEPTH));
  assign rem_left = rem_r - len_rdata;
  assign fill_dec = fill_r - 1'b1;

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    fill_nxt     = fill_r;
    head_tag_nxt = head_tag_r;
    rem_nxt      = rem_r;
    err_nxt      = err_r;
    res_load     = 1'b0;
    res          = brtq_pkg::make_result(fill_r, head_tag_r, err_r);

    ram_req.rd_en     = 1'b0;
    ram_req.rd_addr   = head_r;
    ram_req.len_we    = 1'b0;
    ram_req.tag_we    = 1'b0;
    ram_req.wr_addr   = tail_r;
    ram_req.len_wdata = in_bytes;
    ram_req.tag_wdata = in_tag;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == brtq_pkg::CMD_PUSH) begin
            err_nxt = brtq_pkg::ERR_OK;
            if (in_bytes != '0) begin
              if (full) begin
                err_nxt = brtq_pkg::ERR_FULL;
              end else begin
                ram_req.len_we = 1'b1;
                ram_req.tag_we = 1'b1;
                tail_nxt = brtq_pkg::ring_next(tail_r);
                fill_nxt = fill_r + 1'b1;
                if (fill_r == '0) begin
                  head_tag_nxt = in_tag;
                end
              end
            end
            res_load = 1'b1;
            res      = brtq_pkg::make_result(fill_nxt, head_tag_nxt, err_nxt);
          end else if (in_bytes == '0 || fill_r == '0) begin
            // nothing to walk: answer at once
            err_nxt  = (in_bytes != '0) ? brtq_pkg::ERR_UNDERFLOW : brtq_pkg::ERR_OK;
            res_load = 1'b1;
            res      = brtq_pkg::make_result(fill_r, head_tag_r, err_nxt);
          end else begin
            rem_nxt   = in_bytes;
            state_nxt = ST_LEN_RD;
          end
        end
      end
      ST_LEN_RD: begin
        ram_req.rd_en = 1'b1;
        state_nxt     = ST_LEN_EVAL;
      end
      ST_LEN_EVAL: begin
        if (rem_r >= len_rdata) begin
          // retire the head range
          rem_nxt  = rem_left;
          head_nxt = brtq_pkg::ring_next(head_r);
          fill_nxt = fill_dec;
          if (rem_left != '0 && fill_dec != '0) begin
            state_nxt = ST_LEN_RD;
          end else begin
            err_nxt   = (rem_left != '0) ? brtq_pkg::ERR_UNDERFLOW : brtq_pkg::ERR_OK;
            state_nxt = (fill_dec != '0) ? ST_TAG_RD : ST_DONE;
          end
        end else begin
          // shorten the head range and write it back
          ram_req.len_we    = 1'b1;
          ram_req.wr_addr   = head_r;
          ram_req.len_wdata = len_rdata - rem_r;
          rem_nxt           = '0;
          head_tag_nxt      = tag_rdata;
          err_nxt           = brtq_pkg::ERR_OK;
          state_nxt         = ST_DONE;
        end
      end
      ST_TAG_RD: begin
        ram_req.rd_en = 1'b1;
        state_nxt     = ST_TAG_CAP;
      end
      ST_TAG_CAP: begin
        head_tag_nxt = tag_rdata;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      fill_r  <= '0;
      err_r   <= brtq_pkg::ERR_OK;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      fill_r  <= fill_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_tag_r <= head_tag_nxt;
    rem_r      <= rem_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/byte_range_tag_queue.sv
// Byte range tag queue: a ring of byte ranges, each with a 32-bit tag.
//
// Requests arrive on the in_ stream: in_tuser selects push (0) or consume (1),
// in_tdata carries the byte count and the tag. Every request gives exactly one
// result on the out_ stream: head tag, head valid, entry count, error code.
// Request handling:
//   push, zero-byte consume, consume on an empty queue: result registered in
//   the accept cycle, one request per cycle while the output register is free.
//   consume that walks ranges: for each head range, a read of its length from
//   the length memory, then a retire or a shortening write-back; when the walk
//   stops exactly at the end of a range and ranges remain, a fetch of the new
//   head tag; then the result is presented.
// The length and tag memories have one read and one write port each; the walk
// over the head lengths, one memory read at a time, sets the consume rate.
// Reset clears pointers and fill count at once; no clearing pass follows.
// A stalled receiver holds the result in the output register; every request
// waits until that register is free before it is accepted, and a longer
// consume then runs and waits for it again before it presents its result.
// Depends on brtq_pkg, brtq_ram and brtq_ctrl.
`default_nettype none

module byte_range_tag_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] byte_count, [63:32] tag_value
  input  wire logic        in_tuser,   // [0] cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // [31:0] head_tag, [32] head_valid,
                                       // [37:33] entry_count, [39:38] error_code
);

  brtq_pkg::ram_req_t ram_req;
  brtq_pkg::word_t    len_rdata;
  brtq_pkg::word_t    tag_rdata;
  brtq_pkg::result_t  res;
  brtq_pkg::result_t  out_data_r;
  logic               res_load;
  logic               out_valid_r, out_valid_nxt;
  logic               out_free;

  assign out_free = !out_valid_r || out_tready;

  brtq_ram #(
    .WIDTH (brtq_pkg::DATA_W),
    .DEPTH (brtq_pkg::QUEUE_DEPTH)
  ) u_len_ram (
    .clk     (clk),
    .wr_en   (ram_req.len_we),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.len_wdata),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (len_rdata)
  );

  brtq_ram #(
    .WIDTH (brtq_pkg::DATA_W),
    .DEPTH (brtq_pkg::QUEUE_DEPTH)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (ram_req.tag_we),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.tag_wdata),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (tag_rdata)
  );

  brtq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser),
    .in_bytes  (in_tdata[31:0]),
    .in_tag    (in_tdata[63:32]),
    .out_free  (out_free),
    .len_rdata (len_rdata),
    .tag_rdata (tag_rdata),
    .ram_req   (ram_req),
    .res_load  (res_load),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

FILE: rtl/brtq_checker.sv
// Port-level checks of the byte range tag queue, bound to the top level.
// Depends on brtq_pkg and byte_range_tag_queue_macros.svh.
`default_nettype none
`include "byte_range_tag_queue_macros.svh"

module brtq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);

  logic [31:0]                  chk_tag;
  logic                         chk_valid;
  logic [4:0]                   chk_count;
  logic [brtq_pkg::ERR_W-1:0]   chk_err;

  assign chk_tag   = out_tdata[31:0];
  assign chk_valid = out_tdata[32];
  assign chk_count = out_tdata[37:33];
  assign chk_err   = out_tdata[39:38];

  // hold a stalled result
  `BRTQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata), "stalled result changed")

  `BRTQ_ASSERT_NOW(a_valid_count, clk, rst_n, out_tvalid,
    chk_valid == (chk_count != 5'd0), "head_valid disagrees with entry_count")

  `BRTQ_ASSERT_NOW(a_empty_tag, clk, rst_n, out_tvalid && !chk_valid,
    chk_tag == 32'd0, "empty queue reports a nonzero tag")

  `BRTQ_ASSERT_NOW(a_count_err, clk, rst_n, out_tvalid,
    (32'(chk_count) <= 32'(brtq_pkg::QUEUE_DEPTH)) && (chk_err != brtq_pkg::ERR_RESERVED),
    "entry_count or error_code out of range")

endmodule

bind byte_range_tag_queue brtq_checker u_brtq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
